/* hw/rtl/cbq_pkg.sv */
package cbq_pkg;

   localparam int NUM_SEC_BITS  = 5;
   localparam int SEC_IDX_BITS  = 4;
   localparam int SLOT_BITS     = 3;
   localparam int NUM_SLOTS     = 5;
   localparam int GUARD_BITS    = 8;
   localparam int COEF_INT_BITS = 4;
   localparam int TERM_BITS     = 3;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [TERM_BITS-1:0] term_type;
   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   localparam logic OPCODE_FILTER = 1'b0;
   localparam logic OPCODE_COEF   = 1'b1;

   localparam slot_type SLOT_B0 = 3'd0;
   localparam slot_type SLOT_B1 = 3'd1;
   localparam slot_type SLOT_B2 = 3'd2;
   localparam slot_type SLOT_A1 = 3'd3;
   localparam slot_type SLOT_A2 = 3'd4;

   localparam slot_mask_type ALL_SLOTS = 5'b11111;

   // order of the multiply-accumulate terms within one section
   localparam term_type TERM_A1 = 3'd0;
   localparam term_type TERM_A2 = 3'd1;
   localparam term_type TERM_B0 = 3'd2;
   localparam term_type TERM_B1 = 3'd3;
   localparam term_type TERM_B2 = 3'd4;

   function automatic slot_type term_slot(input term_type term);
      slot_type slot;
      unique case (term)
         TERM_A1: slot = SLOT_A1;
         TERM_A2: slot = SLOT_A2;
         TERM_B0: slot = SLOT_B0;
         TERM_B1: slot = SLOT_B1;
         default: slot = SLOT_B2;
      endcase
      return slot;
   endfunction

endpackage

/* hw/rtl/cascaded_biquad_filter.sv */
// each sample item runs through the enabled sections in turn, and a section in use that
// is not fully loaded passes it through; the result is then registered for the response
// a new sample item is taken only in idle; the single shared multiplier and the
// one-read coefficient memory run five multiply-accumulates per section in turn
// coefficient write items are taken in idle and give no result
// synchronous active-high reset clears control, coefficient written flags and delay valid flags
module cascaded_biquad_filter #(
   parameter int MAX_SECTIONS = 16,
   parameter int SAMPLE_BITS  = 24,
   parameter int COEF_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic [cbq_pkg::SEC_IDX_BITS-1:0]     req_section_index,
   input  logic [cbq_pkg::SLOT_BITS-1:0]        req_coef_slot,
   input  logic signed [COEF_BITS-1:0]          req_coef_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbq_pkg::NUM_SEC_BITS-1:0]     csr_data
);
   import cbq_pkg::*;

   localparam int DELAY_BITS = SAMPLE_BITS + GUARD_BITS;
   localparam int FRAC_BITS  = COEF_BITS - COEF_INT_BITS;
   localparam int PROD_BITS  = COEF_BITS + DELAY_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int Q_BITS     = ACC_BITS - FRAC_BITS;
   localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
   localparam int CMP_W      = (CNT_W > NUM_SEC_BITS) ? CNT_W : NUM_SEC_BITS;
   localparam int COEF_DEPTH = MAX_SECTIONS * NUM_SLOTS;
   localparam int ADDR_W     = $clog2(COEF_DEPTH);

   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [CMP_W-1:0] MAX_SEC_CNT = CMP_W'(MAX_SECTIONS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEC  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_RND0 = 3'd5;
   localparam logic [2:0] ST_RND1 = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              sec_ff, sec_in;
   term_type                      term_ff, term_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          clip_ff, clip_in;
   logic signed [DELAY_BITS-1:0]  w0_ff, w0_in;
   logic signed [DELAY_BITS-1:0]  w1_ff, w1_in;
   logic signed [DELAY_BITS-1:0]  w2_ff, w2_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_sat_ff, rsp_sat_in;
   logic [NUM_SEC_BITS-1:0]       num_sec_ff, num_sec_in;
   slot_mask_type                 wmask_ff [MAX_SECTIONS];
   logic [MAX_SECTIONS-1:0]       dvld_ff, dvld_in;

   logic signed [COEF_BITS-1:0]    coef_mem [COEF_DEPTH];
   logic signed [COEF_BITS-1:0]    coef_q_ff;
   logic [2*DELAY_BITS-1:0]        dly_mem [MAX_SECTIONS];
   logic [2*DELAY_BITS-1:0]        dly_q_ff;

   logic                     coef_we;
   logic [ADDR_W-1:0]        coef_waddr;
   logic                     coef_re;
   logic [ADDR_W-1:0]        coef_raddr;
   slot_type                 rd_slot;
   logic                     dly_we;
   logic                     dly_re;
   logic [SEC_W-1:0]         sec_idx;
   logic [SEC_W-1:0]         wr_sec;
   logic [CMP_W-1:0]         n_eff;
   logic                     wr_ok;
   logic                     req_fire;
   logic signed [DELAY_BITS-1:0] opnd;
   logic signed [ACC_BITS-1:0]   prod_ext;
   logic signed [ACC_BITS-1:0]   rnd_sum;
   logic [Q_BITS-1:0]            q;
   logic                         dly_ok;
   logic                         smp_ok;
   logic signed [DELAY_BITS-1:0] dly_rnd;
   logic signed [SAMPLE_BITS-1:0] smp_rnd;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

   assign req_fire = req_valid && req_ready;
   assign sec_idx  = sec_ff[SEC_W-1:0];
   assign wr_sec   = SEC_W'(req_section_index);
   assign n_eff    = (CMP_W'(num_sec_ff) > MAX_SEC_CNT) ? MAX_SEC_CNT : CMP_W'(num_sec_ff);
   assign wr_ok    = (CMP_W'(req_section_index) < MAX_SEC_CNT)
                     && (req_coef_slot <= SLOT_A2);

   assign coef_waddr = ADDR_W'(ADDR_W'(wr_sec) * ADDR_W'(NUM_SLOTS))
                       + ADDR_W'(req_coef_slot);
   assign coef_raddr = ADDR_W'(ADDR_W'(sec_idx) * ADDR_W'(NUM_SLOTS)) + ADDR_W'(rd_slot);

   // operand of the current term: a1,b1 use w1, a2,b2 use w2, b0 uses w0
   always_comb begin
      unique case (term_ff)
         TERM_A1, TERM_B1: opnd = w1_ff;
         TERM_A2, TERM_B2: opnd = w2_ff;
         default:          opnd = w0_ff;
      endcase
   end

   assign prod_in  = coef_q_ff * opnd;
   assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

   // round half up, then clip to the delay or sample range
   assign rnd_sum = acc_ff + HALF;
   assign q       = rnd_sum[ACC_BITS-1:FRAC_BITS];
   assign dly_ok  = (&q[Q_BITS-1:DELAY_BITS-1]) || !(|q[Q_BITS-1:DELAY_BITS-1]);
   assign smp_ok  = (&q[Q_BITS-1:SAMPLE_BITS-1]) || !(|q[Q_BITS-1:SAMPLE_BITS-1]);
   assign dly_rnd = dly_ok ? q[DELAY_BITS-1:0]
                           : {q[Q_BITS-1], {(DELAY_BITS-1){~q[Q_BITS-1]}}};
   assign smp_rnd = smp_ok ? q[SAMPLE_BITS-1:0]
                           : {q[Q_BITS-1], {(SAMPLE_BITS-1){~q[Q_BITS-1]}}};

   always_comb begin
      state_in      = state_ff;
      sec_in        = sec_ff;
      term_in       = term_ff;
      x_in          = x_ff;
      clip_in       = clip_ff;
      w0_in         = w0_ff;
      w1_in         = w1_ff;
      w2_in         = w2_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      num_sec_in    = num_sec_ff;
      dvld_in       = dvld_ff;
      coef_we       = 1'b0;
      coef_re       = 1'b0;
      rd_slot       = term_slot(term_ff);
      dly_we        = 1'b0;
      dly_re        = 1'b0;

      if (csr_valid && csr_ready) begin
         num_sec_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OPCODE_FILTER) begin
                  x_in     = req_sample_in;
                  clip_in  = 1'b0;
                  sec_in   = '0;
                  state_in = ST_SEC;
               end else begin
                  coef_we = wr_ok;
               end
            end
         end
         ST_SEC: begin
            if (CMP_W'(sec_ff) >= n_eff) begin
               state_in = ST_OUT;
            end else if (wmask_ff[sec_idx] != ALL_SLOTS) begin
               // a section that is not fully loaded passes the signal through
               sec_in = sec_ff + CNT_W'(1);
            end else begin
               term_in  = TERM_A1;
               rd_slot  = SLOT_A1;
               coef_re  = 1'b1;
               dly_re   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (dvld_ff[sec_idx]) begin
               w1_in = dly_q_ff[DELAY_BITS-1:0];
               w2_in = dly_q_ff[2*DELAY_BITS-1:DELAY_BITS];
            end else begin
               w1_in = '0;
               w2_in = '0;
            end
            acc_in   = {{(ACC_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff} <<< FRAC_BITS;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (term_ff == TERM_A1 || term_ff == TERM_A2) begin
               acc_in = acc_ff - prod_ext;
            end else begin
               acc_in = acc_ff + prod_ext;
            end
            if (term_ff == TERM_B2) begin
               state_in = ST_RND1;
            end else begin
               term_in  = term_ff + TERM_BITS'(1);
               rd_slot  = term_slot(term_ff + TERM_BITS'(1));
               coef_re  = 1'b1;
               state_in = (term_ff == TERM_A2) ? ST_RND0 : ST_MUL;
            end
         end
         ST_RND0: begin
            w0_in    = dly_rnd;
            clip_in  = clip_ff || !dly_ok;
            acc_in   = '0;
            state_in = ST_MUL;
         end
         ST_RND1: begin
            x_in             = smp_rnd;
            clip_in          = clip_ff || !smp_ok;
            dly_we           = 1'b1;
            dvld_in[sec_idx] = 1'b1;
            sec_in           = sec_ff + CNT_W'(1);
            state_in         = ST_SEC;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = x_ff;
               rsp_sat_in    = clip_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sec_ff       <= '0;
         term_ff      <= TERM_A1;
         rsp_valid_ff <= 1'b0;
         num_sec_ff   <= '0;
         dvld_ff      <= '0;
         for (int i = 0; i < MAX_SECTIONS; i++) begin
            wmask_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
         num_sec_ff   <= num_sec_in;
         dvld_ff      <= dvld_in;
         if (coef_we) begin
            wmask_ff[wr_sec] <= wmask_ff[wr_sec] | (NUM_SLOTS'(1) << req_coef_slot);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      clip_ff       <= clip_in;
      w0_ff         <= w0_in;
      w1_ff         <= w1_in;
      w2_ff         <= w2_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_coef_value;
      end
      if (coef_re) begin
         coef_q_ff <= coef_mem[coef_raddr];
      end
   end

   // delay row holds {w2, w1}
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[sec_idx] <= {w1_ff, w0_ff};
      end
      if (dly_re) begin
         dly_q_ff <= dly_mem[sec_idx];
      end
   end

`ifndef SYNTH
   a_sample_starts_chain: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OPCODE_FILTER |=> state_ff == ST_SEC && sec_ff == '0)
      else $error("sample item did not start the section chain");

   a_sec_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(sec_ff) <= MAX_SEC_CNT)
      else $error("section counter beyond last section");

   a_mac_only_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> wmask_ff[sec_idx] == ALL_SLOTS)
      else $error("filter work on a section that is not fully loaded");

   a_no_overwrite_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && state_ff == ST_OUT |=> state_ff == ST_OUT)
      else $error("result overwritten while still waiting");
`endif

endmodule
